>>> rtl/core/atss_pkg.sv
// Shared types, constants and the segment decoder for the temperature display block.
// No dependencies.
package atss_pkg;

  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 13;

  localparam logic [CfgIdxW-1:0] CFG_IDX_REF    = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_IDX_OFFSET = 2'd1;

  localparam logic [12:0] REF_RESET    = 13'd3300;
  localparam logic [9:0]  OFFSET_RESET = 10'd500;

  // x/10 = (x*52429)>>19 for x < 2^13, x/10 = (x*205)>>11 and x/100 = (x*41)>>12 for x < 1000
  localparam logic [15:0] RECIP10_WIDE = 16'd52429;
  localparam logic [7:0]  RECIP10      = 8'd205;
  localparam logic [5:0]  RECIP100     = 6'd41;

  localparam logic [1:0] LAST_DIGIT = 2'd3;

  localparam logic [7:0] SEG_MINUS = 8'hBF;
  localparam logic [7:0] SEG_OFF   = 8'hFF;

  typedef struct packed {
    logic [12:0] ref_mv;
    logic [9:0]  offset_mv;
  } atss_cfg_t;

  typedef struct packed {
    logic       neg;
    logic [9:0] mag;
    logic [6:0] q1;
    logic [3:0] q2;
  } atss_mag_t;

  function automatic logic [7:0] seg_of(input logic [3:0] digit);
    logic [7:0] seg;
    case (digit)
      4'd0:    seg = 8'hC0;
      4'd1:    seg = 8'hF9;
      4'd2:    seg = 8'hA4;
      4'd3:    seg = 8'hB0;
      4'd4:    seg = 8'h99;
      4'd5:    seg = 8'h92;
      4'd6:    seg = 8'h82;
      4'd7:    seg = 8'hF8;
      4'd8:    seg = 8'h80;
      4'd9:    seg = 8'h90;
      default: seg = SEG_OFF;
    endcase
    return seg;
  endfunction

endpackage

>>> rtl/core/atss_convert.sv
// Sample to magnitude pipeline: input register, millivolt scaling, offset and /10, digit split.
// Depends on atss_pkg.
module atss_convert (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  atss_pkg::atss_cfg_t   cfg_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [9:0]            adc_sample_i,
  output logic                  mag_valid_o,
  input  logic                  mag_ready_i,
  output atss_pkg::atss_mag_t   mag_o
);
  import atss_pkg::*;

  logic [3:0]  v_q, v_d;
  logic [3:0]  rdy;
  logic [9:0]  s0_sample_q;
  logic [12:0] s1_mv_q;
  logic        s2_neg_q;
  logic [9:0]  s2_mag_q;
  atss_mag_t   s3_q;

  logic [22:0] prod_mv;
  logic [12:0] off_ext;
  logic [12:0] diff;
  logic [28:0] prod_div;
  logic [17:0] prod_q1;
  logic [15:0] prod_q2;

  assign rdy[3] = !v_q[3] || mag_ready_i;
  assign rdy[2] = !v_q[2] || rdy[3];
  assign rdy[1] = !v_q[1] || rdy[2];
  assign rdy[0] = !v_q[0] || rdy[1];

  assign in_stall_o  = !rdy[0];
  assign mag_valid_o = v_q[3];
  assign mag_o       = s3_q;

  always_comb begin
    v_d = v_q;
    if (rdy[0]) v_d[0] = in_valid_i;
    if (rdy[1]) v_d[1] = v_q[0];
    if (rdy[2]) v_d[2] = v_q[1];
    if (rdy[3]) v_d[3] = v_q[2];
  end

  assign prod_mv  = 23'(s0_sample_q) * 23'(cfg_i.ref_mv);
  assign off_ext  = {3'b000, cfg_i.offset_mv};
  assign diff     = (s1_mv_q >= off_ext) ? (s1_mv_q - off_ext) : (off_ext - s1_mv_q);
  assign prod_div = 29'(diff) * 29'(RECIP10_WIDE);
  assign prod_q1  = 18'(s2_mag_q) * 18'(RECIP10);
  assign prod_q2  = 16'(s2_mag_q) * 16'(RECIP100);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0] && in_valid_i) begin
      s0_sample_q <= adc_sample_i;
    end
    if (rdy[1] && v_q[0]) begin
      s1_mv_q <= prod_mv[22:10];
    end
    if (rdy[2] && v_q[1]) begin
      s2_neg_q <= (s1_mv_q < off_ext);
      s2_mag_q <= prod_div[28:19];
    end
    if (rdy[3] && v_q[2]) begin
      s3_q.neg <= s2_neg_q && (s2_mag_q != '0);
      s3_q.mag <= s2_mag_q;
      s3_q.q1  <= prod_q1[17:11];
      s3_q.q2  <= prod_q2[15:12];
    end
  end

endmodule

>>> rtl/core/atss_serializer.sv
// Digit decode and four-digit output shifter, units first.
// Depends on atss_pkg.
module atss_serializer (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  mag_valid_i,
  output logic                  mag_ready_o,
  input  atss_pkg::atss_mag_t   mag_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [7:0]            segments_o,
  output logic [1:0]            digit_index_o,
  output logic                  last_digit_o
);
  import atss_pkg::*;

  logic       busy_q, busy_d;
  logic [1:0] cnt_q, cnt_d;
  logic [7:0] seg_q [4];
  logic [7:0] seg_d [4];
  logic       fire;
  logic       load;
  logic [9:0] ten_q1;
  logic [9:0] units_w;
  logic [6:0] ten_q2;
  logic [6:0] tens_w;

  assign fire        = busy_q && !out_stall_i;
  assign mag_ready_o = !busy_q || (fire && (cnt_q == LAST_DIGIT));
  assign load        = mag_ready_o && mag_valid_i;

  assign ten_q1  = {mag_i.q1, 3'b000} + {2'b00, mag_i.q1, 1'b0};
  assign units_w = mag_i.mag - ten_q1;
  assign ten_q2  = {mag_i.q2, 3'b000} + {2'b00, mag_i.q2, 1'b0};
  assign tens_w  = mag_i.q1 - ten_q2;

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    seg_d  = seg_q;
    if (fire) begin
      cnt_d    = cnt_q + 2'd1;
      seg_d[0] = seg_q[1];
      seg_d[1] = seg_q[2];
      seg_d[2] = seg_q[3];
      seg_d[3] = SEG_OFF;
      if (cnt_q == LAST_DIGIT) busy_d = 1'b0;
    end
    if (load) begin
      busy_d   = 1'b1;
      cnt_d    = '0;
      seg_d[0] = seg_of(units_w[3:0]);
      seg_d[1] = seg_of(tens_w[3:0]);
      seg_d[2] = seg_of(mag_i.q2);
      seg_d[3] = mag_i.neg ? SEG_MINUS : seg_of(4'd0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    seg_q <= seg_d;
  end

  assign out_valid_o   = busy_q;
  assign segments_o    = seg_q[0];
  assign digit_index_o = cnt_q;
  assign last_digit_o  = (cnt_q == LAST_DIGIT);

endmodule

>>> rtl/core/adc_temp_to_seven_segment.sv
// Converter sample to four seven-segment digit requests, units digit first.
// Path: input register, millivolt scaling, offset and /10, digit split, then the digit shifter;
// digits follow one per cycle while out_stall_i is low. The shifter takes a new sample as its
// last digit leaves; the four-stage scaling pipeline keeps taking samples as digits drain.
// Reset: pipeline and shifter empty, reference 3300 mV, offset 500 mV.
module adc_temp_to_seven_segment (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [atss_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [atss_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [9:0]                   adc_sample_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [7:0]                   segments_o,
  output logic [1:0]                   digit_index_o,
  output logic                         last_digit_o
);
  import atss_pkg::*;

  atss_cfg_t cfg_q;
  atss_mag_t mag;
  logic      mag_valid;
  logic      mag_ready;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ref_mv    <= REF_RESET;
      cfg_q.offset_mv <= OFFSET_RESET;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CFG_IDX_REF) begin
        cfg_q.ref_mv <= cfg_data_i;
      end else if (cfg_index_i == CFG_IDX_OFFSET) begin
        cfg_q.offset_mv <= cfg_data_i[9:0];
      end
    end
  end

  atss_convert u_convert (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .adc_sample_i (adc_sample_i),
    .mag_valid_o  (mag_valid),
    .mag_ready_i  (mag_ready),
    .mag_o        (mag)
  );

  atss_serializer u_serializer (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .mag_valid_i   (mag_valid),
    .mag_ready_o   (mag_ready),
    .mag_i         (mag),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .segments_o    (segments_o),
    .digit_index_o (digit_index_o),
    .last_digit_o  (last_digit_o)
  );

endmodule

>>> rtl/core/atss_checker.sv
// Port-level checks for the temperature display block, bound to the top level.
// Depends on atss_pkg.
module atss_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          cfg_valid_i,
  input logic                          cfg_ready_o,
  input logic [atss_pkg::CfgIdxW-1:0]  cfg_index_i,
  input logic [atss_pkg::CfgDataW-1:0] cfg_data_i,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input logic [9:0]                    adc_sample_i,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic [7:0]                    segments_o,
  input logic [1:0]                    digit_index_o,
  input logic                          last_digit_o
);
  import atss_pkg::*;

  logic unused;
  assign unused = cfg_valid_i ^ cfg_ready_o ^ (^cfg_index_i) ^ (^cfg_data_i)
                  ^ in_valid_i ^ in_stall_o ^ (^adc_sample_i);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(segments_o)
                                   && $stable(digit_index_o))
    else $error("digit request changed while stalled");

  a_index_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_digit_o |=>
      out_valid_o && (digit_index_o == $past(digit_index_o) + 2'd1))
    else $error("digit sequence broken");

  a_last_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (last_digit_o == (digit_index_o == LAST_DIGIT)))
    else $error("last flag not on top digit");

  a_top_digit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_digit_o |-> (segments_o == SEG_MINUS) || (segments_o == 8'hC0))
    else $error("top digit neither zero nor minus");

  a_dp_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> segments_o[7])
    else $error("decimal point lit");

endmodule

bind adc_temp_to_seven_segment atss_checker u_atss_checker (.*);

>>> tb/testbench.sv
// Self-checking testbench for adc_temp_to_seven_segment: predicts the four digit requests of
// every sample and compares them in order. Uses atss_pkg and the RTL under rtl/core.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import atss_pkg::*;

  localparam logic [CfgIdxW-1:0] CFG_IDX_SPARE_LO = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_IDX_SPARE_HI = 2'd3;
  localparam int unsigned        NumPhases        = 10;
  localparam int unsigned        PhaseSamples     = 36;
  localparam int unsigned        HoldCycles       = 120;
  localparam int unsigned        SettleCycles     = 10;

  typedef struct packed {
    logic [7:0] seg;
    logic [1:0] idx;
    logic       last;
  } digit_req_t;

  class digit_scoreboard;
    logic [12:0] ref_mv;
    logic [9:0]  offset_mv;
    logic [7:0]  seg_code [10];
    digit_req_t  digit_q [$];
    int          errors;

    function new();
      ref_mv    = REF_RESET;
      offset_mv = OFFSET_RESET;
      seg_code  = '{8'hC0, 8'hF9, 8'hA4, 8'hB0, 8'h99, 8'h92, 8'h82, 8'hF8, 8'h80, 8'h90};
      errors    = 0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] index, logic [CfgDataW-1:0] data);
      case (index)
        CFG_IDX_REF:    ref_mv = data;
        CFG_IDX_OFFSET: offset_mv = data[9:0];
        default: ;
      endcase
    endfunction

    function void note_sample(logic [9:0] sample);
      int unsigned mv;
      int unsigned mag;
      int unsigned dig [4];
      logic        neg;
      digit_req_t  d;
      mv = (int'(sample) * int'(ref_mv)) >> 10;
      if (mv >= offset_mv) begin
        neg = 1'b0;
        mag = (mv - offset_mv) / 10;
      end else begin
        mag = (offset_mv - mv) / 10;
        neg = (mag != 0);
      end
      dig[0] = mag % 10;
      dig[1] = (mag / 10) % 10;
      dig[2] = (mag / 100) % 10;
      dig[3] = (mag / 1000) % 10;
      for (int k = 0; k < 4; k++) begin
        d.idx  = k[1:0];
        d.last = (d.idx == LAST_DIGIT);
        d.seg  = (d.last && neg) ? SEG_MINUS : seg_code[dig[k]];
        digit_q.push_back(d);
      end
    endfunction

    function void check_digit(logic [7:0] seg, logic [1:0] idx, logic last);
      digit_req_t want;
      if (digit_q.size() == 0) begin
        $display("%0t: unexpected request seg=%h idx=%0d last=%0b", $time, seg, idx, last);
        errors++;
        return;
      end
      want = digit_q.pop_front();
      if (seg !== want.seg) begin
        $display("%0t: segments expected %h actual %h", $time, want.seg, seg);
        errors++;
      end
      if (idx !== want.idx) begin
        $display("%0t: digit_index expected %0d actual %0d", $time, want.idx, idx);
        errors++;
      end
      if (last !== want.last) begin
        $display("%0t: last_digit expected %0b actual %0b", $time, want.last, last);
        errors++;
      end
    endfunction

    function int pending();
      return digit_q.size();
    endfunction
  endclass

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                cfg_valid = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data  = '0;
  logic                in_valid  = 1'b0;
  logic [9:0]          adc       = '0;
  logic                out_stall = 1'b0;
  logic                cfg_ready;
  logic                in_stall;
  logic                out_valid;
  logic [7:0]          segments;
  logic [1:0]          digit_index;
  logic                last_digit;

  bit          quiet_tx  = 1'b0;
  bit          quiet_rx  = 1'b0;
  bit          hold_req  = 1'b0;
  int unsigned hold_left = 0;

  digit_scoreboard board = new();

  adc_temp_to_seven_segment dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .adc_sample_i (adc),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .segments_o   (segments),
    .digit_index_o(digit_index),
    .last_digit_o (last_digit)
  );

  always #5 clk = ~clk;

  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = HoldCycles;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= !quiet_rx && ($urandom_range(99) < 33);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      board.check_digit(segments, digit_index, last_digit);
    end
  end

  task automatic write_cfg(input logic [CfgIdxW-1:0] index, input logic [CfgDataW-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    board.write_reg(index, data);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_sample(input logic [9:0] sample);
    int unsigned gap;
    gap = (quiet_tx || $urandom_range(99) >= 33) ? 0 : $urandom_range(1, 4);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    adc      <= sample;
    do @(posedge clk); while (in_stall);
    board.note_sample(sample);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // mostly uniform, some rail values, some samples close to the zero-degree point
  function automatic logic [9:0] pick_sample(int unsigned ref_v, int unsigned off_v);
    int unsigned roll;
    int unsigned c;
    roll = $urandom_range(99);
    if (roll < 10) return roll[0] ? 10'd1023 : 10'd0;
    if (roll < 40 && ref_v != 0) begin
      c = (off_v * 1024) / ref_v + $urandom_range(8);
      c = (c < 4) ? 0 : c - 4;
      if (c > 1023) c = 1023;
      return c[9:0];
    end
    return 10'($urandom_range(1023));
  endfunction

  logic [9:0]          directed [18] = '{10'd0, 10'd1023, 10'd1, 10'd2, 10'd150, 10'd151,
                                         10'd153, 10'd155, 10'd156, 10'd158, 10'd200, 10'd310,
                                         10'd511, 10'd512, 10'd620, 10'd800, 10'd1000, 10'd682};
  logic [CfgDataW-1:0] ref_set [7]  = '{13'd1000, 13'd5000, 13'd1000, 13'h1FFF, 13'd3300,
                                        13'd0, 13'd5000};
  logic [CfgDataW-1:0] off_set [7]  = '{13'd0, 13'd1000, 13'd1000, 13'h1FFF, 13'd500,
                                        13'd700, 13'd0};

  initial begin
    logic [CfgDataW-1:0] ref_w;
    logic [CfgDataW-1:0] off_w;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (directed[i]) send_sample(directed[i]);
    drain();

    for (int p = 0; p < NumPhases; p++) begin
      if (p < 7) begin
        ref_w = ref_set[p];
        off_w = off_set[p];
      end else begin
        ref_w = 13'($urandom_range(1000, 5000));
        off_w = 13'($urandom_range(1000));
      end
      write_cfg(CFG_IDX_REF, ref_w);
      write_cfg(CFG_IDX_OFFSET, off_w);
      if (p == 2) begin
        write_cfg(CFG_IDX_SPARE_LO, 13'($urandom));
        write_cfg(CFG_IDX_SPARE_HI, 13'($urandom));
      end
      quiet_tx = (p == 4) || (p == 6);
      quiet_rx = (p == 4);
      if (p == 6) hold_req = 1'b1;
      repeat (PhaseSamples) send_sample(pick_sample(board.ref_mv, board.offset_mv));
      drain();
    end

    if (board.errors == 0) begin
      $display("adc_temp_to_seven_segment: match");
    end else begin
      $display("adc_temp_to_seven_segment: mismatch");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("adc_temp_to_seven_segment: mismatch");
    $finish;
  end

endmodule

>>> files.f
rtl/core/atss_pkg.sv
rtl/core/atss_convert.sv
rtl/core/atss_serializer.sv
rtl/core/adc_temp_to_seven_segment.sv
rtl/core/atss_checker.sv
tb/testbench.sv
